// File: design/rpr_pkg.sv
// Shared constants, codes and transaction types for the reader progress rank block.
`default_nettype none

package rpr_pkg;

    localparam int USERS_DEF   = 65536;
    localparam int PAGES_DEF   = 1024;
    localparam int UID_W       = 16;
    localparam int PAGE_W      = 10;
    localparam int CNT_W       = 17;
    localparam int FRAC_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // query of an out-of-range user answers as for a user who has not read
    typedef enum logic [1:0] {
        KIND_UPDATE,
        KIND_QUERY,
        KIND_QUERY_NONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [UID_W-1:0]   uid;
        logic [PAGE_W-1:0]  page;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

`default_nettype wire

// File: design/rpr_front.sv
// Front end: takes transactions, drops ignored updates, classifies the rest for the queue.
`default_nettype none

module rpr_front #(
    parameter int USERS = rpr_pkg::USERS_DEF,
    parameter int PAGES = rpr_pkg::PAGES_DEF
) (
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       opcode,
    input  wire logic [rpr_pkg::UID_W-1:0]  user_id,
    input  wire logic [rpr_pkg::PAGE_W-1:0] page,
    input  wire logic                       clearing,
    input  wire rpr_pkg::queue_status_t     q_status,
    output logic                            push,
    output rpr_pkg::cmd_t                   push_cmd
);
    import rpr_pkg::*;

    logic accept;
    logic uid_ok;
    logic page_ok;

    assign busy    = clearing | q_status.full;
    assign accept  = start & ~busy;
    assign uid_ok  = (32'(user_id) < USERS);
    assign page_ok = (page != '0) && (32'(page) < PAGES);

    always_comb
    begin
        push_cmd.uid  = user_id;
        push_cmd.page = page;
        push          = 1'b0;
        push_cmd.kind = KIND_UPDATE;
        if (opcode == OP_QUERY)
        begin
            push          = accept;
            push_cmd.kind = uid_ok ? KIND_QUERY : KIND_QUERY_NONE;
        end
        else
        begin
            push = accept & uid_ok & page_ok;
        end
    end

endmodule

`default_nettype wire

// File: design/rpr_cmd_fifo.sv
// Short command queue between the front end and the execution engine.
`default_nettype none

module rpr_cmd_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire rpr_pkg::cmd_t          push_cmd,
    input  wire logic                   pop,
    output rpr_pkg::cmd_t               head_cmd,
    output rpr_pkg::queue_status_t      q_status
);
    import rpr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_status.full  = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign q_status.valid = (count_reg != '0);
    assign head_cmd       = entry_reg[rd_ptr_reg];
    assign do_push        = push & ~q_status.full;
    assign do_pop         = pop & q_status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/rpr_back.sv
// Execution engine: user page and histogram memories, bin sweep and serial divider.
`default_nettype none

module rpr_back #(
    parameter int USERS = rpr_pkg::USERS_DEF,
    parameter int PAGES = rpr_pkg::PAGES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rpr_pkg::cmd_t               head_cmd,
    input  wire rpr_pkg::queue_status_t      q_status,
    output logic                             pop,
    output logic                             clearing,
    output logic                             done,
    output logic [rpr_pkg::CNT_W-1:0]        share_q16,
    output logic [rpr_pkg::CNT_W-1:0]        users_behind,
    output logic [rpr_pkg::CNT_W-1:0]        active_count
);
    import rpr_pkg::*;

    localparam int USER_DEPTH = (USERS < (1 << UID_W)) ? USERS : (1 << UID_W);
    localparam int PAGE_DEPTH = (PAGES < (1 << PAGE_W)) ? PAGES : (1 << PAGE_W);
    localparam int CLR_DEPTH  = (USER_DEPTH > PAGE_DEPTH) ? USER_DEPTH : PAGE_DEPTH;
    localparam int UADDR_W    = $clog2(USER_DEPTH);
    localparam int PADDR_W    = $clog2(PAGE_DEPTH);
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int BC_W       = $clog2(FRAC_W + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] ONE_SHARE = CNT_W'(1) << FRAC_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_U_OLD,
        S_U_DEC,
        S_U_INC_RD,
        S_U_INC_WR,
        S_Q_CUR,
        S_Q_SUM,
        S_Q_DIV
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // memories
    logic [PAGE_W-1:0] user_mem [USER_DEPTH];
    logic [CNT_W-1:0]  pop_mem  [PAGE_DEPTH];

    logic               umem_we;
    logic [UADDR_W-1:0] umem_addr;
    logic [PAGE_W-1:0]  umem_wdata;
    logic [PAGE_W-1:0]  urd_reg;

    logic               pmem_we;
    logic [PADDR_W-1:0] pmem_waddr;
    logic [PADDR_W-1:0] pmem_raddr;
    logic [CNT_W-1:0]   pmem_wdata;
    logic [CNT_W-1:0]   prd_reg;

    // control and working registers
    state_t            state_reg, state_next;
    logic [CLR_W-1:0]  clr_idx_reg, clr_idx_next;
    cmd_t              cmd_reg, cmd_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [PAGE_W-1:0] idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [BC_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  share_reg, share_next;
    logic [CNT_W-1:0]  behind_reg, behind_next;
    logic [CNT_W-1:0]  act_out_reg, act_out_next;

    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic [PAGE_W-1:0] cur_page;

    assign clearing     = (state_reg == S_CLEAR);
    assign done         = done_reg;
    assign share_q16    = share_reg;
    assign users_behind = behind_reg;
    assign active_count = act_out_reg;

    assign divisor = active_reg - 1'b1;
    assign rem_sh  = {rem_reg, 1'b0};
    assign q_bit   = (rem_sh >= {1'b0, divisor});
    assign cur_page = (cmd_reg.kind == KIND_QUERY) ? urd_reg : '0;

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        cmd_next     = cmd_reg;
        page_next    = page_reg;
        idx_next     = idx_reg;
        pend_next    = pend_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        bit_cnt_next = bit_cnt_reg;
        active_next  = active_reg;
        done_next    = 1'b0;
        share_next   = share_reg;
        behind_next  = behind_reg;
        act_out_next = act_out_reg;

        pop        = 1'b0;
        umem_we    = 1'b0;
        umem_addr  = cmd_reg.uid[UADDR_W-1:0];
        umem_wdata = cmd_reg.page;
        pmem_we    = 1'b0;
        pmem_waddr = page_reg[PADDR_W-1:0];
        pmem_raddr = cmd_reg.page[PADDR_W-1:0];
        pmem_wdata = '0;

        case (state_reg)
            S_CLEAR:
            begin
                umem_we    = (32'(clr_idx_reg) < USER_DEPTH);
                umem_addr  = clr_idx_reg[UADDR_W-1:0];
                umem_wdata = '0;
                pmem_we    = (32'(clr_idx_reg) < PAGE_DEPTH);
                pmem_waddr = clr_idx_reg[PADDR_W-1:0];
                pmem_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                umem_addr = head_cmd.uid[UADDR_W-1:0];
                if (q_status.valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    state_next = (head_cmd.kind == KIND_UPDATE) ? S_U_OLD : S_Q_CUR;
                end
            end
            S_U_OLD:
            begin
                // old page is on the read port; store the new one
                umem_we    = 1'b1;
                page_next  = urd_reg;
                pmem_raddr = urd_reg[PADDR_W-1:0];
                if (urd_reg == '0)
                begin
                    active_next = sat_inc(active_reg);
                    state_next  = S_U_INC_RD;
                end
                else
                begin
                    state_next = S_U_DEC;
                end
            end
            S_U_DEC:
            begin
                pmem_we    = 1'b1;
                pmem_waddr = page_reg[PADDR_W-1:0];
                pmem_wdata = sat_dec(prd_reg);
                state_next = S_U_INC_RD;
            end
            S_U_INC_RD:
            begin
                pmem_raddr = cmd_reg.page[PADDR_W-1:0];
                state_next = S_U_INC_WR;
            end
            S_U_INC_WR:
            begin
                pmem_we    = 1'b1;
                pmem_waddr = cmd_reg.page[PADDR_W-1:0];
                pmem_wdata = sat_inc(prd_reg);
                state_next = S_IDLE;
            end
            S_Q_CUR:
            begin
                if (cur_page == '0)
                begin
                    done_next    = 1'b1;
                    share_next   = '0;
                    behind_next  = '0;
                    act_out_next = active_reg;
                    state_next   = S_IDLE;
                end
                else
                begin
                    page_next  = cur_page;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    acc_next   = '0;
                    state_next = S_Q_SUM;
                end
            end
            S_Q_SUM:
            begin
                // one bin read issued per cycle, summed in the cycle after
                pmem_raddr = idx_reg[PADDR_W-1:0];
                if (pend_reg)
                begin
                    acc_next = sat_add(acc_reg, prd_reg);
                end
                if (idx_reg < page_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        behind_next  = acc_reg;
                        act_out_next = active_reg;
                        if ((active_reg <= CNT_W'(1)) || (acc_reg >= divisor))
                        begin
                            share_next = ONE_SHARE;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rem_next     = acc_reg;
                            quo_next     = '0;
                            bit_cnt_next = BC_W'(FRAC_W);
                            state_next   = S_Q_DIV;
                        end
                    end
                end
            end
            S_Q_DIV:
            begin
                rem_next     = q_bit ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
                quo_next     = {quo_reg[FRAC_W-2:0], q_bit};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BC_W'(1))
                begin
                    share_next = {1'b0, quo_reg[FRAC_W-2:0], q_bit};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            pend_reg    <= 1'b0;
            active_reg  <= '0;
            done_reg    <= 1'b0;
            share_reg   <= '0;
            behind_reg  <= '0;
            act_out_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            pend_reg    <= pend_next;
            active_reg  <= active_next;
            done_reg    <= done_next;
            share_reg   <= share_next;
            behind_reg  <= behind_next;
            act_out_reg <= act_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        page_reg    <= page_next;
        idx_reg     <= idx_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (umem_we)
        begin
            user_mem[umem_addr] <= umem_wdata;
        end
        urd_reg <= user_mem[umem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            pop_mem[pmem_waddr] <= pmem_wdata;
        end
        prd_reg <= pop_mem[pmem_raddr];
    end

endmodule

`default_nettype wire

// File: design/reader_progress_percentile_rank.sv
// Top level of the reader progress percentile rank block.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  command  | start in, busy out    | opcode, user_id, page
//  result   | done out (one cycle)  | share_q16, users_behind, active_count
//
// A command transaction is taken on a rising edge with start high and busy low.
// After reset a clearing pass zeroes both memories over max(user depth, page depth)
// addresses (65536 at the default sizes); busy is high throughout, and also while the
// queue holds two transactions. An update stores the user's new page, decrements the
// old page's bin if there was one and increments the new one; a query runs the
// one-bin-per-cycle histogram sweep and the divider. done is a one-cycle strobe.
`default_nettype none

module reader_progress_percentile_rank #(
    parameter int USERS = rpr_pkg::USERS_DEF,
    parameter int PAGES = rpr_pkg::PAGES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       opcode,
    input  wire logic [rpr_pkg::UID_W-1:0]  user_id,
    input  wire logic [rpr_pkg::PAGE_W-1:0] page,
    output logic                            done,
    output logic [rpr_pkg::CNT_W-1:0]       share_q16,
    output logic [rpr_pkg::CNT_W-1:0]       users_behind,
    output logic [rpr_pkg::CNT_W-1:0]       active_count
);
    import rpr_pkg::*;

    cmd_t          push_cmd;
    cmd_t          head_cmd;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    logic          clearing;

    // front end: drops updates with page zero or an out-of-range user or page, tags queries
    rpr_front #(
        .USERS (USERS),
        .PAGES (PAGES)
    ) u_front (
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .user_id  (user_id),
        .page     (page),
        .clearing (clearing),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples acceptance from execution
    rpr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    // engine: memories, histogram sweep, divider, registered result
    rpr_back #(
        .USERS (USERS),
        .PAGES (PAGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .q_status     (q_status),
        .pop          (pop),
        .clearing     (clearing),
        .done         (done),
        .share_q16    (share_q16),
        .users_behind (users_behind),
        .active_count (active_count)
    );

endmodule

`default_nettype wire

// File: tb/tb_reader_progress_percentile_rank.sv
// Testbench for the reader progress percentile rank block: self-checking, random and directed.
`timescale 1ns / 1ps

module tb_reader_progress_percentile_rank;
    import rpr_pkg::*;

    // Run length. The worst case is the clearing pass plus the queries at the
    // deepest page and the longest sender gaps.
    // The limit is several times that.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int SETTLE_CYCLES = 1200;       // one full-depth query and then some
    localparam int RANDOM_ITEMS = 520;
    localparam int POOL_SIZE    = 40;
    localparam int CNT_MAX      = 131071;
    localparam longint unsigned ONE_Q16 = 65536;

    // One command transaction waiting to be driven.
    typedef struct {
        logic              op;
        logic [UID_W-1:0]  uid;
        logic [PAGE_W-1:0] pg;
        int                gap_pct;   // chance of an idle cycle before it goes out
        bit                drain;     // hold it back until every query has answered
    } request_t;

    // What one query should return.
    typedef struct packed {
        logic [CNT_W-1:0] share;
        logic [CNT_W-1:0] behind;
        logic [CNT_W-1:0] active;
    } rank_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic opcode = OP_UPDATE;
    logic [UID_W-1:0] user_id = '0;
    logic [PAGE_W-1:0] page = '0;
    logic busy;
    logic done;
    logic [CNT_W-1:0] share_q16;
    logic [CNT_W-1:0] users_behind;
    logic [CNT_W-1:0] active_count;

    // Mirror of the block's stores. 2-state so they start at zero, as after reset.
    bit [PAGE_W-1:0] page_of_user [USERS_DEF];
    int unsigned     readers_on_page [PAGES_DEF];
    int unsigned     active_readers;

    request_t cmd_backlog[$];
    rank_t    pending_ranks[$];
    int       queries_issued = 0;    // driver-owned
    int       results_seen   = 0;    // monitor-owned
    int       fault_count    = 0;
    int       cycle_count    = 0;
    int       reader_pool [POOL_SIZE];

    reader_progress_percentile_rank u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .user_id      (user_id),
        .page         (page),
        .done         (done),
        .share_q16    (share_q16),
        .users_behind (users_behind),
        .active_count (active_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Page read: move the user between bins; first read makes them active.
    // Page zero is dropped. Counters saturate, though that cannot be reached here.
    task automatic record_page_read(input logic [UID_W-1:0] uid, input logic [PAGE_W-1:0] pg);
        int unsigned prev;
        if (pg == '0)
            return;
        prev = page_of_user[uid];
        if (prev == 0)
        begin
            if (active_readers < CNT_MAX)
                active_readers++;
        end
        else if (readers_on_page[prev] != 0)
            readers_on_page[prev]--;
        page_of_user[uid] = pg;
        if (readers_on_page[pg] < CNT_MAX)
            readers_on_page[pg]++;
    endtask

    // Share of the other active users standing strictly lower, truncated Q1.16.
    function automatic rank_t rank_of_user(input logic [UID_W-1:0] uid);
        rank_t           r;
        int unsigned     at;
        longint unsigned behind;
        longint unsigned share;
        at = page_of_user[uid];
        behind = 0;
        share = 0;
        if (at != 0)
        begin
            for (int i = 0; i < at; i++)
                behind += readers_on_page[i];
            if (behind > CNT_MAX)
                behind = CNT_MAX;
            // lone reader counts as ahead of everyone
            if (active_readers <= 1)
                share = ONE_Q16;
            else
            begin
                share = (behind << 16) / longint'(active_readers - 1);
                if (share > ONE_Q16)
                    share = ONE_Q16;
            end
        end
        r.share  = share[CNT_W-1:0];
        r.behind = behind[CNT_W-1:0];
        r.active = active_readers[CNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_cmd(input logic op, input int uid, input int pg,
                           input int gap_pct, input bit drain);
        request_t c;
        c.op = op;
        c.uid = uid[UID_W-1:0];
        c.pg = pg[PAGE_W-1:0];
        c.gap_pct = gap_pct;
        c.drain = drain;
        cmd_backlog = {cmd_backlog, c};
    endtask

    // Mostly a small crowd of regulars so updates and queries collide,
    // the rest anywhere in the id space.
    function automatic int pick_user();
        if ($urandom_range(99) < 70)
            return reader_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom_range(65535);
    endfunction

    // Low pages keep the histogram sweep short; a quarter go anywhere.
    function automatic int pick_page();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 0;
        if (roll < 75)
            return $urandom_range(63, 1);
        return $urandom_range(1023);
    endfunction

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
            note_fault($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // ------------------------------------------------------------------
    // Driver: presents one backlog entry at a time and holds start until
    // busy drops. The accepted transaction is fed to the predictor on the
    // same edge, before the block has acted on it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            opcode  <= OP_UPDATE;
            user_id <= '0;
            page    <= '0;
            queries_issued <= 0;
        end
        else
        begin : drive
            bit took;
            int outstanding;
            took = start && !busy;
            outstanding = queries_issued - results_seen;
            if (took)
            begin
                if (opcode == OP_QUERY)
                begin
                    pending_ranks = {pending_ranks, rank_of_user(user_id)};
                    queries_issued <= queries_issued + 1;
                    outstanding++;
                end
                else
                    record_page_read(user_id, page);
            end
            // a held start stays put until the block takes it
            if (!start || took)
            begin
                if (cmd_backlog.size() == 0
                    || (cmd_backlog[0].drain && outstanding != 0)
                    || $urandom_range(99) < cmd_backlog[0].gap_pct)
                    start <= 1'b0;
                else
                begin : present
                    request_t c;
                    c = cmd_backlog.pop_front();
                    start   <= 1'b1;
                    opcode  <= c.op;
                    user_id <= c.uid;
                    page    <= c.pg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, so every edge with done high
    // carries one result that must match the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_seen <= 0;
        else if (done)
        begin
            results_seen <= results_seen + 1;
            if (pending_ranks.size() == 0)
                note_fault($sformatf("unexpected result share=%0d behind=%0d active=%0d",
                                     share_q16, users_behind, active_count));
            else
            begin : compare
                rank_t want;
                want = pending_ranks.pop_front();
                check_field("share_q16", want.share, share_q16);
                check_field("users_behind", want.behind, users_behind);
                check_field("active_count", want.active, active_count);
            end
        end
    end

    // Watchdog: the limit is loose, well beyond the clearing pass.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int gap;
        bit drain;

        for (int i = 0; i < POOL_SIZE; i++)
            reader_pool[i] = $urandom_range(65535);

        // Directed: empty histogram, page zero, extremes of id and page,
        // lone reader, same page twice, moving down, unread users.
        add_cmd(OP_QUERY,  0,      0,     8, 1'b0);  // nobody active yet
        add_cmd(OP_UPDATE, 5,      0,     8, 1'b0);  // page zero is dropped
        add_cmd(OP_QUERY,  5,      0,     8, 1'b0);
        add_cmd(OP_UPDATE, 0,      1023,  8, 1'b0);
        add_cmd(OP_QUERY,  0,      0,     8, 1'b0);  // only reader -> full share
        add_cmd(OP_UPDATE, 65535,  1,     8, 1'b0);
        add_cmd(OP_QUERY,  65535,  1023,  8, 1'b0);  // page field ignored on query
        add_cmd(OP_QUERY,  0,      0,     8, 1'b0);
        add_cmd(OP_UPDATE, 0,      1023,  8, 1'b0);  // same page, bin unchanged
        add_cmd(OP_QUERY,  0,      0,     8, 1'b0);
        add_cmd(OP_UPDATE, 100,    512,   8, 1'b0);
        add_cmd(OP_QUERY,  100,    0,     8, 1'b0);
        add_cmd(OP_UPDATE, 100,    3,     8, 1'b0);  // moves back down
        add_cmd(OP_QUERY,  100,    0,     8, 1'b0);
        add_cmd(OP_QUERY,  0,      0,     8, 1'b0);
        add_cmd(OP_QUERY,  42,     1023,  8, 1'b0);  // never read
        add_cmd(OP_UPDATE, 'hAAAA, 'h155, 8, 1'b0);
        add_cmd(OP_UPDATE, 'h5555, 'h2AA, 8, 1'b0);
        add_cmd(OP_QUERY,  'hAAAA, 'h2AA, 8, 1'b0);
        add_cmd(OP_QUERY,  'h5555, 'h155, 8, 1'b0);
        add_cmd(OP_UPDATE, 65535,  0,     8, 1'b0);  // dropped, stays on page 1
        add_cmd(OP_QUERY,  65535,  0,     8, 1'b0);

        // Random: sender busy, then sparse, then back to back. A drain ahead of
        // each phase and now and then inside one, so the block runs dry too.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS / 3)
                gap = 8;
            else if (i < 2 * RANDOM_ITEMS / 3)
                gap = 79;
            else
                gap = 0;
            drain = (i == 0) || (i == RANDOM_ITEMS / 3) || (i == 2 * RANDOM_ITEMS / 3)
                    || ($urandom_range(99) == 0);
            if ($urandom_range(1) == 0)
                add_cmd(OP_UPDATE, pick_user(), pick_page(), gap, drain);
            else
                add_cmd(OP_QUERY, pick_user(), $urandom_range(1023), gap, drain);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // everything driven and taken, then every query answered
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || start);
        do
            @(posedge clk);
        while (pending_ranks.size() != 0);
        // catch any stray strobe from the last transaction
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_ranks.size() != 0)
            note_fault($sformatf("%0d results never arrived", pending_ranks.size()));
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: reader_progress_percentile_rank.f
design/rpr_pkg.sv
design/rpr_front.sv
design/rpr_cmd_fifo.sv
design/rpr_back.sv
design/reader_progress_percentile_rank.sv
tb/tb_reader_progress_percentile_rank.sv
